@@ rtl/gpsa_pkg.sv @@
// Package for the genotype pair score accumulator.
// Holds shared constants, the command code type and the controller/datapath structs.
// No dependencies.
package gpsa_pkg;

  localparam int unsigned GPSA_MAX_ALLELES = 16;
  localparam int unsigned GPSA_SAMPLES     = 64;
  localparam int unsigned ADDR_W           = 3;

  localparam int unsigned WEIGHT_FLOOR     = 8;
  localparam int unsigned WEIGHT_BIAS      = 4;
  localparam int unsigned PEN_NON_UNIQUE   = 3;
  localparam int unsigned PEN_MAPQ_BAD     = 2;
  localparam int unsigned PEN_CLIPPED      = 3;
  localparam int unsigned PEN_NO_OVERLAP   = 1;
  localparam int unsigned PEN_LOW_QUALITY  = 2;
  localparam logic [16:0] SCORE_LIMIT      = 17'h0FFFF;

  typedef enum logic [1:0] {
    FUNC_CLEAR   = 2'd0,
    FUNC_SCORE   = 2'd1,
    FUNC_REFRESH = 2'd2,
    FUNC_READ    = 2'd3
  } func_e;

  typedef struct packed {
    logic accept;
    logic init_first;
    logic load;
    logic decide;
    logic step;
    logic finish;
    logic next_sample;
  } ctrl_cmd_t;

  typedef struct packed {
    logic in_range_in;
    logic sweep_go;
    logic last;
    logic sample_last;
  } dp_status_t;

endpackage

@@ rtl/gpsa_regs.sv @@
// Configuration registers of the genotype pair score accumulator.
// APB-style write/read port for base_exponent and allele_count; uses gpsa_pkg.
module gpsa_regs (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  output logic [7:0]                  base_exponent_o,
  output logic [4:0]                  allele_count_o
);
  import gpsa_pkg::*;

  typedef enum logic {
    REG_BASE_EXPONENT = 1'b0,
    REG_ALLELE_COUNT  = 1'b1
  } reg_e;

  logic [7:0] base_exponent_q;
  logic [4:0] allele_count_q;
  reg_e       reg_sel;
  logic       wr_en;

  assign reg_sel = reg_e'(paddr[2]);
  assign wr_en   = psel && penable && pwrite;
  assign pready  = 1'b1;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      base_exponent_q <= 8'd16;
      allele_count_q  <= 5'd2;
    end else if (wr_en) begin
      unique case (reg_sel)
        REG_BASE_EXPONENT: base_exponent_q <= pwdata[7:0];
        REG_ALLELE_COUNT:  allele_count_q  <= pwdata[4:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    unique case (reg_sel)
      REG_BASE_EXPONENT: prdata = 32'(base_exponent_q);
      REG_ALLELE_COUNT:  prdata = 32'(allele_count_q);
      default:           prdata = '0;
    endcase
  end

  assign base_exponent_o = base_exponent_q;
  assign allele_count_o  = allele_count_q;

endmodule

@@ rtl/gpsa_ctrl.sv @@
// Controller of the genotype pair score accumulator.
// Sequences reset clearing, command load, table sweep and result; uses gpsa_pkg.
module gpsa_ctrl (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   start_i,
  input  gpsa_pkg::dp_status_t   status_i,
  output gpsa_pkg::ctrl_cmd_t    cmd_o,
  output logic                   busy_o,
  output logic                   done_o
);
  import gpsa_pkg::*;

  typedef enum logic [2:0] {
    S_IDLE,
    S_INIT,
    S_LOAD,
    S_DECIDE,
    S_SWEEP,
    S_DRAIN,
    S_FINISH
  } state_e;

  state_e state_q;
  logic   init_q;
  logic   done_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
      init_q  <= 1'b1;
      done_q  <= 1'b0;
    end else begin
      done_q <= 1'b0;
      unique case (state_q)
        S_IDLE: begin
          if (start_i) begin
            state_q <= status_i.in_range_in ? S_LOAD : S_FINISH;
          end
        end
        S_INIT:   state_q <= S_LOAD;
        S_LOAD:   state_q <= S_DECIDE;
        S_DECIDE: state_q <= status_i.sweep_go ? S_SWEEP : S_FINISH;
        S_SWEEP: begin
          if (status_i.last) begin
            state_q <= S_DRAIN;
          end
        end
        S_DRAIN:  state_q <= S_FINISH;
        S_FINISH: begin
          if (init_q) begin
            if (status_i.sample_last) begin
              init_q  <= 1'b0;
              state_q <= S_IDLE;
            end else begin
              state_q <= S_LOAD;
            end
          end else begin
            done_q  <= 1'b1;
            state_q <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  always_comb begin
    cmd_o             = '0;
    cmd_o.accept      = (state_q == S_IDLE) && start_i;
    cmd_o.init_first  = (state_q == S_INIT);
    cmd_o.load        = (state_q == S_LOAD);
    cmd_o.decide      = (state_q == S_DECIDE);
    cmd_o.step        = (state_q == S_SWEEP);
    cmd_o.finish      = (state_q == S_FINISH);
    cmd_o.next_sample = (state_q == S_FINISH) && init_q && !status_i.sample_last;
  end

  assign busy_o = (state_q != S_IDLE);
  assign done_o = done_q;

endmodule

@@ rtl/gpsa_dp.sv @@
// Datapath of the genotype pair score accumulator.
// Pair score memory, per-sample maximum memory, weight logic and sweep pipeline; uses gpsa_pkg.
module gpsa_dp #(
  parameter int unsigned MAX_ALLELES = gpsa_pkg::GPSA_MAX_ALLELES,
  parameter int unsigned SAMPLES     = gpsa_pkg::GPSA_SAMPLES
) (
  input  logic                  clk_i,
  input  logic                  rst_ni,
  input  gpsa_pkg::ctrl_cmd_t   cmd_i,
  output gpsa_pkg::dp_status_t  status_o,
  input  logic [7:0]            base_exponent_i,
  input  logic [4:0]            allele_count_i,
  input  logic [1:0]            func_i,
  input  logic [5:0]            sample_index_i,
  input  logic [15:0]           allele_set_i,
  input  logic [7:0]            mismatch_count_i,
  input  logic                  non_unique_i,
  input  logic                  mapq_bad_i,
  input  logic                  fully_aligned_i,
  input  logic                  overlaps_variant_i,
  input  logic                  low_quality_i,
  input  logic [7:0]            entry_index_i,
  output logic [15:0]           max_score_o,
  output logic [15:0]           entry_value_o,
  output logic [7:0]            weight_used_o,
  output logic                  added_o
);
  import gpsa_pkg::*;

  localparam int unsigned PE    = MAX_ALLELES * (MAX_ALLELES + 1) / 2;
  localparam int unsigned TOTAL = SAMPLES * PE;
  localparam int unsigned AW    = $clog2(TOTAL);
  localparam int unsigned IW    = $clog2(PE);
  localparam int unsigned SW    = (SAMPLES > 1) ? $clog2(SAMPLES) : 1;
  localparam int unsigned SX    = (SW > 6) ? SW : 6;
  localparam int unsigned YW    = $clog2(MAX_ALLELES);
  localparam int unsigned NW    = $clog2(MAX_ALLELES + 1);
  localparam int unsigned CW    = 2 * NW;

  logic [15:0] pair_mem [TOTAL];
  logic [15:0] max_mem  [SAMPLES];

  func_e       func_q;
  logic [SW-1:0] sample_q;
  logic [15:0] set_q;
  logic [7:0]  eidx_q;
  logic [7:0]  weight_q;
  logic [CW-1:0] used_q;
  logic        in_range_q;
  logic [AW-1:0] base_q;
  logic [IW-1:0] idx_q;
  logic [IW-1:0] last_q;
  logic        empty_q;
  logic [YW-1:0] x_q;
  logic [YW-1:0] y_q;
  logic [15:0] max_rdata_q;
  logic [15:0] max_q;
  logic [15:0] entry_q;
  logic        added_q;
  logic [15:0] pair_rdata_q;
  logic        p_valid_q;
  logic [AW-1:0] p_addr_q;
  logic [7:0]  p_delta_q;
  logic [15:0] max_score_q;
  logic [15:0] entry_value_q;
  logic [7:0]  weight_used_q;
  logic        added_out_q;

  logic [SX-1:0] s_ext;
  logic [3:0]  pen_flags;
  logic [8:0]  pen_sum;
  logic [9:0]  pen_floor;
  logic [7:0]  weight_d;
  logic [NW-1:0] n_use;
  logic [CW-1:0] used_d;
  logic        add_now;
  logic [AW-1:0] rd_addr;
  logic [MAX_ALLELES-1:0] set_ext;
  logic        ex;
  logic        ey;
  logic [7:0]  delta_d;
  logic        wr_en;
  logic [15:0] wr_data;

  assign s_ext = SX'(sample_index_i);

  always_comb begin
    pen_flags = (non_unique_i ? 4'(PEN_NON_UNIQUE) : 4'd0)
              + (mapq_bad_i ? 4'(PEN_MAPQ_BAD) : 4'd0)
              + (fully_aligned_i ? 4'd0 : 4'(PEN_CLIPPED))
              + (overlaps_variant_i ? 4'd0 : 4'(PEN_NO_OVERLAP))
              + (low_quality_i ? 4'(PEN_LOW_QUALITY) : 4'd0);
    pen_sum   = 9'(mismatch_count_i) + 9'(pen_flags);
    pen_floor = 10'(pen_sum) + 10'(WEIGHT_FLOOR);
    if (10'(base_exponent_i) < pen_floor) begin
      weight_d = 8'(WEIGHT_FLOOR - WEIGHT_BIAS);
    end else begin
      weight_d = 8'(10'(base_exponent_i) - 10'(pen_sum) - 10'(WEIGHT_BIAS));
    end
  end

  assign n_use  = (32'(allele_count_i) > 32'(MAX_ALLELES)) ? NW'(MAX_ALLELES)
                                                            : NW'(allele_count_i);
  assign used_d = (CW'(n_use) * (CW'(n_use) + CW'(1))) >> 1;

  assign add_now = (17'(max_rdata_q) + 17'(weight_q)) < SCORE_LIMIT;
  assign rd_addr = base_q + AW'(idx_q);
  assign set_ext = MAX_ALLELES'(set_q);
  assign ex      = set_ext[x_q];
  assign ey      = set_ext[y_q];
  assign delta_d = (ex && ey) ? weight_q : ((ex || ey) ? (weight_q - 8'd1) : 8'd0);

  assign wr_en   = p_valid_q && ((func_q == FUNC_CLEAR) || (func_q == FUNC_SCORE));
  assign wr_data = (func_q == FUNC_CLEAR) ? 16'd0 : (pair_rdata_q + 16'(p_delta_q));

  assign status_o.in_range_in = 32'(sample_index_i) < 32'(SAMPLES);
  assign status_o.sweep_go    = !empty_q && ((func_q != FUNC_SCORE) || add_now);
  assign status_o.last        = (idx_q == last_q);
  assign status_o.sample_last = (sample_q == SW'(SAMPLES - 1));

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_valid_q <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.step;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.accept) begin
      func_q     <= func_e'(func_i);
      sample_q   <= s_ext[SW-1:0];
      set_q      <= allele_set_i;
      eidx_q     <= entry_index_i;
      weight_q   <= weight_d;
      used_q     <= used_d;
      in_range_q <= status_o.in_range_in;
    end
    if (cmd_i.init_first) begin
      func_q     <= FUNC_CLEAR;
      sample_q   <= '0;
      in_range_q <= 1'b1;
    end
    if (cmd_i.next_sample) begin
      sample_q <= sample_q + SW'(1);
    end

    if (cmd_i.load) begin
      base_q  <= AW'(sample_q) * AW'(PE);
      x_q     <= '0;
      y_q     <= '0;
      entry_q <= '0;
      added_q <= 1'b0;
      case (func_q)
        FUNC_CLEAR: begin
          idx_q   <= '0;
          last_q  <= IW'(PE - 1);
          empty_q <= 1'b0;
        end
        FUNC_READ: begin
          idx_q   <= IW'(eidx_q);
          last_q  <= IW'(eidx_q);
          empty_q <= 32'(eidx_q) >= 32'(PE);
        end
        default: begin
          idx_q   <= '0;
          last_q  <= IW'(used_q - CW'(1));
          empty_q <= (used_q == '0);
        end
      endcase
    end

    if (cmd_i.decide) begin
      case (func_q)
        FUNC_SCORE: begin
          added_q <= add_now;
          max_q   <= add_now ? (max_rdata_q + 16'(weight_q)) : max_rdata_q;
        end
        FUNC_READ: max_q <= max_rdata_q;
        default:   max_q <= '0;
      endcase
    end

    if (cmd_i.step) begin
      p_addr_q  <= rd_addr;
      p_delta_q <= delta_d;
      idx_q     <= idx_q + IW'(1);
      if (x_q == y_q) begin
        x_q <= '0;
        y_q <= y_q + YW'(1);
      end else begin
        x_q <= x_q + YW'(1);
      end
    end

    if (p_valid_q) begin
      case (func_q)
        FUNC_REFRESH: begin
          if (pair_rdata_q > max_q) begin
            max_q <= pair_rdata_q;
          end
        end
        FUNC_READ: entry_q <= pair_rdata_q;
        default: ;
      endcase
    end

    if (cmd_i.finish) begin
      max_score_q   <= in_range_q ? max_q : 16'd0;
      entry_value_q <= in_range_q ? entry_q : 16'd0;
      weight_used_q <= (in_range_q && (func_q == FUNC_SCORE)) ? weight_q : 8'd0;
      added_out_q   <= in_range_q && added_q;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      pair_mem[p_addr_q] <= wr_data;
    end
    pair_rdata_q <= pair_mem[rd_addr];
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.finish && in_range_q) begin
      max_mem[sample_q] <= max_q;
    end
    max_rdata_q <= max_mem[sample_q];
  end

  assign max_score_o   = max_score_q;
  assign entry_value_o = entry_value_q;
  assign weight_used_o = weight_used_q;
  assign added_o       = added_out_q;

endmodule

@@ rtl/genotype_pair_score_accumulator.sv @@
// Top level of the genotype pair score accumulator.
// Instantiates gpsa_regs, gpsa_ctrl and gpsa_dp; uses gpsa_pkg.
//
// Channel   | Handshake               | Payload
// ----------+-------------------------+-------------------------------------------
// command   | start, busy             | func_i .. entry_index_i
// result    | done_o (one-cycle pulse)| max_score_o, entry_value_o, weight_used_o,
//           |                         | added_o
// config    | psel, penable, pwrite   | paddr, pwdata, prdata, pready
//
// A score or refresh item sweeps the N*(N+1)/2 pairs in use (N alleles in use), a clear
// item all PE = MAX_ALLELES*(MAX_ALLELES+1)/2 entries and a read item one entry. An item
// skips the sweep when the score is not applied, no pairs are in use or the entry is
// out of range. The pair score memory, with one read and one write port, handles one
// entry a cycle during the sweep. After reset a clearing pass keeps busy high.
// The result pulse cannot be stalled; busy drops in the cycle the result shows.
module genotype_pair_score_accumulator #(
  parameter int unsigned MAX_ALLELES = gpsa_pkg::GPSA_MAX_ALLELES,
  parameter int unsigned SAMPLES     = gpsa_pkg::GPSA_SAMPLES
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        psel,
  input  logic                        penable,
  input  logic                        pwrite,
  input  logic [gpsa_pkg::ADDR_W-1:0] paddr,
  input  logic [31:0]                 pwdata,
  output logic [31:0]                 prdata,
  output logic                        pready,
  input  logic                        start,
  output logic                        busy,
  input  logic [1:0]                  func_i,
  input  logic [5:0]                  sample_index_i,
  input  logic [15:0]                 allele_set_i,
  input  logic [7:0]                  mismatch_count_i,
  input  logic                        non_unique_i,
  input  logic                        mapq_bad_i,
  input  logic                        fully_aligned_i,
  input  logic                        overlaps_variant_i,
  input  logic                        low_quality_i,
  input  logic [7:0]                  entry_index_i,
  output logic                        done_o,
  output logic [15:0]                 max_score_o,
  output logic [15:0]                 entry_value_o,
  output logic [7:0]                  weight_used_o,
  output logic                        added_o
);
  import gpsa_pkg::*;

  logic [7:0] base_exponent;
  logic [4:0] allele_count;
  ctrl_cmd_t  cmd;
  dp_status_t status;

  gpsa_regs u_regs (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready),
    .base_exponent_o (base_exponent),
    .allele_count_o  (allele_count)
  );

  gpsa_ctrl u_ctrl (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .start_i  (start),
    .status_i (status),
    .cmd_o    (cmd),
    .busy_o   (busy),
    .done_o   (done_o)
  );

  gpsa_dp #(
    .MAX_ALLELES (MAX_ALLELES),
    .SAMPLES     (SAMPLES)
  ) u_dp (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .cmd_i              (cmd),
    .status_o           (status),
    .base_exponent_i    (base_exponent),
    .allele_count_i     (allele_count),
    .func_i             (func_i),
    .sample_index_i     (sample_index_i),
    .allele_set_i       (allele_set_i),
    .mismatch_count_i   (mismatch_count_i),
    .non_unique_i       (non_unique_i),
    .mapq_bad_i         (mapq_bad_i),
    .fully_aligned_i    (fully_aligned_i),
    .overlaps_variant_i (overlaps_variant_i),
    .low_quality_i      (low_quality_i),
    .entry_index_i      (entry_index_i),
    .max_score_o        (max_score_o),
    .entry_value_o      (entry_value_o),
    .weight_used_o      (weight_used_o),
    .added_o            (added_o)
  );

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy) else $error("result shown while busy");

  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy) else $error("accepted item did not raise busy");

  a_single_pulse: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o) else $error("result strobe longer than one cycle");

  a_added_weight: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && added_o) |-> (weight_used_o >= 8'(WEIGHT_FLOOR - WEIGHT_BIAS)
                             && max_score_o >= 16'(weight_used_o)))
    else $error("added item with inconsistent weight or maximum");

endmodule
